### hdl/tksi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksi_pkg
// Shared widths, constants and types of the top-k sorted insertion table.
// ----------------------------------------------------------------------------
package tksi_pkg;

	localparam int SCORE_W = 32;
	localparam int TAG_W   = 24;
	localparam int POS_W   = 3;
	localparam int SLOTS   = 5;

	localparam logic [POS_W-1:0] POS_NOT_PLACED = 3'd5;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [TAG_W-1:0]   tag;
	} entry_t;

	// What a cell hands to the cell below it.
	typedef struct packed {
		logic   gt;
		entry_t entry;
	} link_t;

	// What a cell reports to the control logic.
	typedef struct packed {
		logic   take_new;
		entry_t nxt;
	} cell_stat_t;

	typedef struct packed {
		logic               placed;
		logic [POS_W-1:0]   position;
		entry_t [SLOTS-1:0] table_e;
	} result_t;

endpackage

### hdl/tksi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksi_in_if / tksi_out_if
// Valid/ready channels for the offered entries and for the table results.
// ----------------------------------------------------------------------------
interface tksi_in_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [tksi_pkg::SCORE_W-1:0]  score;
	logic [tksi_pkg::TAG_W-1:0]    tag;

	modport source (output valid, mode, score, tag, input ready);
	modport sink (input valid, mode, score, tag, output ready);
endinterface

interface tksi_out_if;
	logic                          valid;
	logic                          ready;
	logic                          placed;
	logic [tksi_pkg::POS_W-1:0]    position;
	logic [tksi_pkg::SCORE_W-1:0]  score_0;
	logic [tksi_pkg::SCORE_W-1:0]  score_1;
	logic [tksi_pkg::SCORE_W-1:0]  score_2;
	logic [tksi_pkg::SCORE_W-1:0]  score_3;
	logic [tksi_pkg::SCORE_W-1:0]  score_4;
	logic [tksi_pkg::TAG_W-1:0]    tag_0;
	logic [tksi_pkg::TAG_W-1:0]    tag_1;
	logic [tksi_pkg::TAG_W-1:0]    tag_2;
	logic [tksi_pkg::TAG_W-1:0]    tag_3;
	logic [tksi_pkg::TAG_W-1:0]    tag_4;

	modport source (output valid, placed, position, score_0, score_1, score_2, score_3,
		score_4, tag_0, tag_1, tag_2, tag_3, tag_4, input ready);
	modport sink (input valid, placed, position, score_0, score_1, score_2, score_3,
		score_4, tag_0, tag_1, tag_2, tag_3, tag_4, output ready);
endinterface

### hdl/tksi_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksi_cell
// One rank of the table: compares the offered entry with its own and either
// holds, takes the offered entry, or takes the entry of the rank above.
// ----------------------------------------------------------------------------
module tksi_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                force_gt,
	input  tksi_pkg::entry_t    offer,
	input  tksi_pkg::link_t     up,
	output tksi_pkg::link_t     down,
	output tksi_pkg::cell_stat_t stat
);
	import tksi_pkg::*;

	entry_t entry_q;
	entry_t nxt;
	logic   gt;

	always_comb begin
		gt = (offer.score > entry_q.score) | force_gt;
		stat.take_new = gt & ~up.gt;
		if (up.gt) begin
			nxt = up.entry;
		end else if (gt) begin
			nxt = offer;
		end else begin
			nxt = entry_q;
		end
		stat.nxt = nxt;
		down.gt = gt;
		down.entry = entry_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (en) begin
			entry_q <= nxt;
		end
	end

endmodule

### hdl/top_k_sorted_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_sorted_insert
// Keeps the ENTRIES highest scores with their tags in descending order; with mode set, the
// last rank takes the offered entry when no rank above takes it. Each result beat is registered
// and valid in the cycle after its input beat is accepted. Throughput: one beat per cycle while
// no result beat waits untaken; every rank compares and shifts at once. The output register frees
// its slot in the cycle its beat is taken. Reset clears every kept score and tag to zero and empties the output.
// ----------------------------------------------------------------------------
module top_k_sorted_insert #(
	parameter int ENTRIES = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	tksi_in_if.sink    in_ch,
	tksi_out_if.source out_ch
);
	import tksi_pkg::*;

	entry_t               offer;
	link_t  [ENTRIES:0]   links;
	cell_stat_t [ENTRIES-1:0] stats;
	logic                 accept;
	logic                 out_valid_q;
	result_t              res_q;
	result_t              res_nxt;

	assign offer.score = in_ch.score;
	assign offer.tag   = in_ch.tag;
	assign in_ch.ready = ~out_valid_q | out_ch.ready;
	assign accept      = in_ch.valid & in_ch.ready;
	assign links[0]    = '0;

	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		tksi_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (accept),
			.force_gt ((k == ENTRIES - 1) ? in_ch.mode : 1'b0),
			.offer    (offer),
			.up       (links[k]),
			.down     (links[k+1]),
			.stat     (stats[k])
		);
	end

	always_comb begin
		res_nxt = '0;
		res_nxt.placed = links[ENTRIES].gt;
		res_nxt.position = POS_NOT_PLACED;
		for (int k = 0; k < ENTRIES; k++) begin
			res_nxt.table_e[k] = stats[k].nxt;
			if (stats[k].take_new) begin
				res_nxt.position = POS_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_nxt;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.placed   = res_q.placed;
	assign out_ch.position = res_q.position;
	assign out_ch.score_0  = res_q.table_e[0].score;
	assign out_ch.score_1  = res_q.table_e[1].score;
	assign out_ch.score_2  = res_q.table_e[2].score;
	assign out_ch.score_3  = res_q.table_e[3].score;
	assign out_ch.score_4  = res_q.table_e[4].score;
	assign out_ch.tag_0    = res_q.table_e[0].tag;
	assign out_ch.tag_1    = res_q.table_e[1].tag;
	assign out_ch.tag_2    = res_q.table_e[2].tag;
	assign out_ch.tag_3    = res_q.table_e[3].tag;
	assign out_ch.tag_4    = res_q.table_e[4].tag;

endmodule
